// File: sv/eftl_pkg.sv
package eftl_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned MAX_HEIGHT_DEF = 2048;

    localparam int unsigned PIXEL_W   = 8;
    localparam int unsigned COORD_W   = 11;
    localparam int unsigned COUNT_W   = 12;
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [PIXEL_W-1:0] EDGE_VALUE      = 8'd255;
    localparam logic [CFG_W-1:0]   FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0]   FRAME_HEIGHT_RST = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

endpackage

// File: sv/eftl_pixel_if.sv
interface eftl_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [eftl_pkg::PIXEL_W-1:0]  pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

// File: sv/eftl_result_if.sv
interface eftl_result_if;
    logic                          valid;
    logic                          ready;
    logic [eftl_pkg::COORD_W-1:0]  left_x;
    logic [eftl_pkg::COORD_W-1:0]  right_x;
    logic [eftl_pkg::COORD_W-1:0]  level_row;
    logic [eftl_pkg::COUNT_W-1:0]  level_columns;
    logic                          edge_found;

    modport source (output valid, output left_x, output right_x, output level_row,
                    output level_columns, output edge_found, input ready);
    modport sink   (input valid, input left_x, input right_x, input level_row,
                    input level_columns, input edge_found, output ready);
endinterface

// File: sv/eftl_cfg_if.sv
interface eftl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [eftl_pkg::CFG_IDX_W-1:0]  index;
    logic [eftl_pkg::CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/eftl_seen_mem.sv
module eftl_seen_mem #(
    parameter int unsigned DEPTH  = eftl_pkg::MAX_WIDTH_DEF,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data
);

    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/edge_frame_table_locator.sv
// Result: loaded from stage s1 as a frame's last pixel beat leaves it. Throughput: one
// pixel per cycle unless a frame-end beat waits for the result slot; the seen-bit RAM is
// read at accept and written as the beat leaves s1, with a forward for back-to-back beats
// on the same column. Reset: frame_width 640, frame_height 480, frame state cleared;
// no RAM clearing pass, a per-frame fill count masks stale seen bits.
module edge_frame_table_locator #(
    parameter int unsigned MAX_WIDTH  = eftl_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = eftl_pkg::MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    eftl_pixel_if.sink            pixel,
    eftl_result_if.source         result,
    eftl_cfg_if.sink              cfg
);

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
    localparam int unsigned CNT_W = COL_W + 1;

    typedef struct packed {
        logic             edge_pix;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             row_end;
        logic             frame_end;
        logic             hit;
    } s1_t;

    // configuration
    logic [eftl_pkg::CFG_W-1:0] frame_width_reg;
    logic [eftl_pkg::CFG_W-1:0] frame_height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= eftl_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= eftl_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            case (eftl_pkg::cfg_reg_t'(cfg.index))
                eftl_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                eftl_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // last column / row after clamping
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;

    always_comb
    begin
        if (frame_width_reg == '0)
            col_last = '0;
        else if (32'(frame_width_reg) > MAX_WIDTH)
            col_last = COL_W'(MAX_WIDTH - 1);
        else
            col_last = COL_W'(frame_width_reg - 12'd1);

        if (frame_height_reg == '0)
            row_last = '0;
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            row_last = ROW_W'(MAX_HEIGHT - 1);
        else
            row_last = ROW_W'(frame_height_reg - 12'd1);
    end

    // handshake
    logic s1_valid_reg;
    s1_t  s1_reg;
    logic res_valid_reg;
    logic out_free;
    logic s1_go;
    logic in_accept;

    assign out_free  = !res_valid_reg || result.ready;
    assign s1_go     = s1_valid_reg && (!s1_reg.frame_end || out_free);
    assign pixel.ready = !s1_valid_reg || s1_go;
    assign in_accept = pixel.valid && pixel.ready;

    // raster counters and fill count (columns written so far this frame)
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W:0]   fill_reg;
    logic [COL_W:0]   col_inc;
    logic             row_end;
    logic             frame_end;

    assign col_inc   = {1'b0, col_reg} + {{COL_W{1'b0}}, 1'b1};
    assign row_end   = col_reg >= col_last;
    assign frame_end = row_end && (row_reg >= row_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            fill_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= row_end ? '0 : col_inc[COL_W-1:0];
            if (frame_end)
            begin
                row_reg  <= '0;
                fill_reg <= '0;
            end
            else
            begin
                if (row_end)
                    row_reg <= row_reg + {{(ROW_W-1){1'b0}}, 1'b1};
                if (col_inc > fill_reg)
                    fill_reg <= col_inc;
            end
        end
    end

    // seen-bit RAM
    logic seen_rd;
    logic seen_old;
    logic seen_new;
    logic byp_reg;
    logic byp_val_reg;

    assign seen_old = s1_reg.hit && (byp_reg ? byp_val_reg : seen_rd);
    assign seen_new = seen_old || s1_reg.edge_pix;

    eftl_seen_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_seen_mem (
        .clk     (clk),
        .wr_en   (s1_go),
        .wr_addr (s1_reg.col),
        .wr_data (seen_new),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (seen_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg.edge_pix  <= pixel.pixel_value == eftl_pkg::EDGE_VALUE;
            s1_reg.col       <= col_reg;
            s1_reg.row       <= row_reg;
            s1_reg.row_end   <= row_end;
            s1_reg.frame_end <= frame_end;
            s1_reg.hit       <= {1'b0, col_reg} < fill_reg;
            // forward the write that lands on the same edge as this read
            byp_reg     <= s1_valid_reg && (s1_reg.col == col_reg) && !s1_reg.frame_end;
            byp_val_reg <= seen_new;
        end
    end

    // frame accumulators
    logic             any_reg;
    logic [COL_W-1:0] min_reg;
    logic [COL_W-1:0] max_reg;
    logic [CNT_W-1:0] row_new_reg;
    logic [CNT_W-1:0] best_cnt_reg;
    logic [ROW_W-1:0] best_row_reg;

    logic             any_upd;
    logic [COL_W-1:0] min_upd;
    logic [COL_W-1:0] max_upd;
    logic [CNT_W-1:0] rnc_sum;
    logic [CNT_W-1:0] best_cnt_upd;
    logic [ROW_W-1:0] best_row_upd;

    always_comb
    begin
        any_upd = any_reg || s1_reg.edge_pix;
        min_upd = (s1_reg.edge_pix && (s1_reg.col < min_reg)) ? s1_reg.col : min_reg;
        max_upd = (s1_reg.edge_pix && (s1_reg.col > max_reg)) ? s1_reg.col : max_reg;
        rnc_sum = row_new_reg + {{(CNT_W-1){1'b0}}, (s1_reg.edge_pix && !seen_old)};
        best_cnt_upd = best_cnt_reg;
        best_row_upd = best_row_reg;
        if (s1_reg.row_end && (rnc_sum > best_cnt_reg))
        begin
            best_cnt_upd = rnc_sum;
            best_row_upd = s1_reg.row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg      <= 1'b0;
            min_reg      <= '1;
            max_reg      <= '0;
            row_new_reg  <= '0;
            best_cnt_reg <= '0;
            best_row_reg <= '0;
        end
        else if (s1_go)
        begin
            if (s1_reg.frame_end)
            begin
                any_reg      <= 1'b0;
                min_reg      <= '1;
                max_reg      <= '0;
                row_new_reg  <= '0;
                best_cnt_reg <= '0;
                best_row_reg <= '0;
            end
            else
            begin
                any_reg      <= any_upd;
                min_reg      <= min_upd;
                max_reg      <= max_upd;
                row_new_reg  <= s1_reg.row_end ? '0 : rnc_sum;
                best_cnt_reg <= best_cnt_upd;
                best_row_reg <= best_row_upd;
            end
        end
    end

    // result register
    logic [31:0] left_wide;
    logic [31:0] right_wide;
    logic [31:0] lrow_wide;
    logic [31:0] lcnt_wide;

    assign left_wide  = any_upd ? 32'(min_upd) : 32'd0;
    assign right_wide = any_upd ? 32'(max_upd) : 32'd0;
    assign lrow_wide  = 32'(best_row_upd);
    assign lcnt_wide  = 32'(best_cnt_upd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_reg.frame_end)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_reg.frame_end)
        begin
            result.left_x        <= left_wide[eftl_pkg::COORD_W-1:0];
            result.right_x       <= right_wide[eftl_pkg::COORD_W-1:0];
            result.level_row     <= lrow_wide[eftl_pkg::COORD_W-1:0];
            result.level_columns <= lcnt_wide[eftl_pkg::COUNT_W-1:0];
            result.edge_found    <= any_upd;
        end
    end

    assign result.valid = res_valid_reg;

endmodule
